/* rtl/tcw_pkg.sv */
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CNT_W   = 5;
    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int NIB_W   = 4;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F00;
    localparam logic [NIB_W-1:0]  FG_RESET   = 4'hF;
    localparam logic [NIB_W-1:0]  BG_RESET   = 4'h0;

    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT    = 3'd0,
        MODE_CLEAR  = 3'd1,
        MODE_MOVE   = 3'd2,
        MODE_SCROLL = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  pos;
        logic              wr;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;
    } t_result;

endpackage

/* rtl/tcw_cell_ram.sv */
module tcw_cell_ram (
    input  logic                          i_clk,
    input  tcw_pkg::t_ram_req             i_req,
    output logic [tcw_pkg::CELL_W-1:0]    o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

/* rtl/tcw_ctrl.sv */
module tcw_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tcw_pkg::MODE_W-1:0]    i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]     i_column,
    input  logic [tcw_pkg::ROW_W-1:0]     i_row,
    input  logic [tcw_pkg::CNT_W-1:0]     i_scroll_count,
    input  logic                          i_update_cursor,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_attr,
    output logic                          o_busy,
    output logic                          o_cfg_reset,
    output tcw_pkg::t_result              o_result,
    output tcw_pkg::t_ram_req             o_ram_req,
    input  logic [tcw_pkg::CELL_W-1:0]    i_rdata
);
    import tcw_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_COPY_RD = 6'b000100,
        S_COPY_WR = 6'b001000,
        S_BLANK   = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(CELLS - 1);

    t_state             r_state;
    logic               r_init;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_ptr;
    logic [ADDR_W-1:0]  r_src;
    t_result            r_res;

    t_mode              r_mode;
    logic [CHAR_W-1:0]  r_code;
    logic [COL_W-1:0]   r_tcol;
    logic [ROW_W-1:0]   r_trow;
    logic [CNT_W-1:0]   r_count;
    logic               r_upd;

    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic               w_put_write;
    logic [COL_W-1:0]   w_sel_col;
    logic [ROW_W-1:0]   w_sel_row;
    logic [ADDR_W-1:0]  w_lin;

    // shared linear address unit: target cell on read, cursor otherwise
    always_comb begin
        if (r_state == S_EXEC && r_mode == MODE_READ) begin
            w_sel_col = r_tcol;
            w_sel_row = r_trow;
        end else begin
            w_sel_col = r_col;
            w_sel_row = r_row;
        end
    end

    assign w_lin = ADDR_W'(32'(w_sel_row) * COLUMNS + 32'(w_sel_col));

    // cursor motion for put char
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        w_put_write = 1'b0;
        case (r_code)
            CH_LF: begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end
            CH_CR: begin
                n_col = '0;
            end
            CH_FF: begin
                n_row = r_row + 1'b1;
            end
            CH_TAB: begin
                n_col = (r_col | COL_W'(3)) + 1'b1;
            end
            CH_BS: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                end
            end
            default: begin
                w_put_write = 1'b1;
                n_col       = r_col + 1'b1;
            end
        endcase
        if (n_col >= COL_W'(COLUMNS)) begin
            n_col = n_col - COL_W'(COLUMNS);
            n_row = n_row + 1'b1;
        end
    end

    always_comb begin
        o_ram_req       = '0;
        o_ram_req.wdata = BLANK_CELL;
        unique case (r_state)
            S_EXEC: begin
                if (r_mode == MODE_PUT && w_put_write) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = w_lin;
                    o_ram_req.wdata = {i_attr, r_code};
                end
                if (r_mode == MODE_READ) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = w_lin;
                end
            end
            S_COPY_RD: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = r_src;
            end
            S_COPY_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_ptr;
                o_ram_req.wdata = i_rdata;
            end
            S_BLANK: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_ptr;
            end
            S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // latch the command beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_mode  <= t_mode'(i_mode);
            r_code  <= i_char_code;
            r_tcol  <= (i_column > COL_MAX) ? COL_MAX : i_column;
            r_trow  <= (i_row > ROW_MAX) ? ROW_MAX : i_row;
            r_count <= i_scroll_count;
            r_upd   <= i_update_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BLANK;
            r_init      <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_ptr       <= '0;
            r_src       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    r_ptr   <= '0;
                    case (r_mode)
                        MODE_PUT: begin
                            r_col <= n_col;
                            if (n_row >= ROW_W'(ROWS)) begin
                                r_row   <= ROW_MAX;
                                r_src   <= ADDR_W'(COLUMNS);
                                r_state <= S_COPY_RD;
                            end else begin
                                r_row <= n_row;
                            end
                        end
                        MODE_CLEAR: begin
                            r_col   <= '0;
                            r_row   <= '0;
                            r_state <= S_BLANK;
                        end
                        MODE_MOVE: begin
                            r_col <= r_tcol;
                            r_row <= r_trow;
                        end
                        MODE_SCROLL: begin
                            if (r_count == '0) begin
                                r_state <= S_DONE;
                            end else if (r_count >= CNT_W'(ROWS)) begin
                                r_row   <= '0;
                                r_state <= S_BLANK;
                            end else begin
                                r_row   <= (r_row > r_count) ? r_row - r_count : '0;
                                r_src   <= ADDR_W'(32'(r_count) * COLUMNS);
                                r_state <= S_COPY_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_COPY_RD: begin
                    r_state <= S_COPY_WR;
                end
                S_COPY_WR: begin
                    r_ptr <= r_ptr + 1'b1;
                    r_src <= r_src + 1'b1;
                    // last source cell moved, blank the vacated rows
                    r_state <= (r_src == ADDR_END) ? S_BLANK : S_COPY_RD;
                end
                S_BLANK: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == ADDR_END) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= (r_state == S_DONE);
        end
        if (r_state == S_DONE) begin
            r_res.pos <= POS_W'(w_lin);
            r_res.wr  <= r_upd & (r_mode == MODE_PUT || r_mode == MODE_MOVE ||
                                  r_mode == MODE_SCROLL);
            if (r_mode == MODE_READ) begin
                r_res.ch   <= i_rdata[CHAR_W-1:0];
                r_res.attr <= i_rdata[CELL_W-1:CHAR_W];
            end else begin
                r_res.ch   <= '0;
                r_res.attr <= '0;
            end
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_reset = (r_state == S_EXEC) && (r_mode == MODE_CLEAR);
    assign o_result    = r_res;

endmodule

/* rtl/text_console_writer.sv */
// Text console engine over a store of 80 x 25 character/attribute cells with a cursor.
// A command beat is taken when i_start is high and o_busy is low; each command gives
// exactly one result on the o_ ports for one cycle, flagged by o_valid, and the result
// cannot be held off. Put char, move cursor and read cell go through the execute and
// result steps of the sequencer; a put char off the last row also scrolls by one line.
// Scrolling by n lines copies (25-n)*80 cells, a read step and a write step each, then
// blanks n*80 cells; clear and a scroll of 25 or more blank all 2000 cells, one per cycle.
// After reset the block runs a clearing pass over the cell store with o_busy high;
// configuration writes are taken at any time, but a clear's colour reset wins over a write.
module text_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [tcw_pkg::MODE_W-1:0]    i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]     i_column,
    input  logic [tcw_pkg::ROW_W-1:0]     i_row,
    input  logic [tcw_pkg::CNT_W-1:0]     i_scroll_count,
    input  logic                          i_update_cursor,
    output logic                          o_valid,
    output logic [tcw_pkg::POS_W-1:0]     o_cursor_pos,
    output logic                          o_cursor_write,
    output logic [tcw_pkg::CHAR_W-1:0]    o_cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]    o_cell_attr,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tcw_pkg::NIB_W-1:0]     i_cfg_data
);
    import tcw_pkg::*;

    logic [NIB_W-1:0]  r_text_fg;
    logic [NIB_W-1:0]  r_text_bg;
    logic              w_cfg_reset;
    t_result           w_result;
    t_ram_req          w_ram_req;
    logic [CELL_W-1:0] w_rdata;

    // clear command returns the colours to their reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_fg <= FG_RESET;
            r_text_bg <= BG_RESET;
        end else if (w_cfg_reset) begin
            r_text_fg <= FG_RESET;
            r_text_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FG:  r_text_fg <= i_cfg_data;
                CFG_BG:  r_text_bg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_scroll_count  (i_scroll_count),
        .i_update_cursor (i_update_cursor),
        .i_attr          ({r_text_bg, r_text_fg}),
        .o_busy          (o_busy),
        .o_cfg_reset     (w_cfg_reset),
        .o_result        (w_result),
        .o_ram_req       (w_ram_req),
        .i_rdata         (w_rdata)
    );

    tcw_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

    assign o_valid        = w_result.valid;
    assign o_cursor_pos   = w_result.pos;
    assign o_cursor_write = w_result.wr;
    assign o_cell_char    = w_result.ch;
    assign o_cell_attr    = w_result.attr;

endmodule

/* sim/tb_text_console_writer.sv */
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 20_000_000;
    localparam int REPORT_MAX  = 10;
    localparam int IDLE_PCT    = 12;
    localparam int TAB_STOP    = 4;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 222;
    localparam int SETTLE      = 20;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CNT_W-1:0]  count;
        logic              upd;
    } t_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [MODE_W-1:0]   i_mode;
    logic [CHAR_W-1:0]   i_char_code;
    logic [COL_W-1:0]    i_column;
    logic [ROW_W-1:0]    i_row;
    logic [CNT_W-1:0]    i_scroll_count;
    logic                i_update_cursor;
    logic                o_valid;
    logic [POS_W-1:0]    o_cursor_pos;
    logic                o_cursor_write;
    logic [CHAR_W-1:0]   o_cell_char;
    logic [CHAR_W-1:0]   o_cell_attr;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [NIB_W-1:0]    i_cfg_data;

    // mirror of the console contents, cursor and colours
    logic [CELL_W-1:0]   shadow_screen [CELLS];
    int                  shadow_col;
    int                  shadow_row;
    logic [NIB_W-1:0]    shadow_fg;
    logic [NIB_W-1:0]    shadow_bg;

    t_result             awaited_status [$];
    int                  fail_count = 0;
    bit                  gaps_on = 1'b1;
    longint unsigned     cycle_count = 0;

    logic [CHAR_W-1:0]   control_codes [5] = '{CH_LF, CH_CR, CH_FF, CH_TAB, CH_BS};

    text_console_writer dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic void screen_blank_all();
        for (int i = 0; i < CELLS; i++)
            shadow_screen[i] = BLANK_CELL;
    endfunction

    function automatic void shadow_reset();
        screen_blank_all();
        shadow_col = 0;
        shadow_row = 0;
        shadow_fg  = FG_RESET;
        shadow_bg  = BG_RESET;
    endfunction

    function automatic void screen_scroll(int n);
        if (n == 0)
            return;
        if (n >= ROWS) begin
            screen_blank_all();
        end else begin
            for (int i = 0; i < CELLS; i++) begin
                if (i < (ROWS - n) * COLUMNS)
                    shadow_screen[i] = shadow_screen[i + n * COLUMNS];
                else
                    shadow_screen[i] = BLANK_CELL;
            end
        end
        shadow_row = (shadow_row > n) ? shadow_row - n : 0;
    endfunction

    function automatic void screen_put(logic [CHAR_W-1:0] code);
        case (code)
            CH_LF: begin
                shadow_col = 0;
                shadow_row++;
            end
            CH_CR:  shadow_col = 0;
            CH_FF:  shadow_row++;
            CH_TAB: shadow_col += TAB_STOP - shadow_col % TAB_STOP;
            CH_BS:  if (shadow_col > 0) shadow_col--;
            default: begin
                shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_bg, shadow_fg, code};
                shadow_col++;
            end
        endcase
        if (shadow_col >= COLUMNS) begin
            shadow_col -= COLUMNS;
            shadow_row++;
        end
        if (shadow_row >= ROWS)
            screen_scroll(1);
    endfunction

    function automatic t_result console_step(t_cmd c);
        t_result           r;
        int                col;
        int                row;
        logic [CELL_W-1:0] entry;
        r       = '0;
        r.valid = 1'b1;
        col = (c.col > COLUMNS - 1) ? COLUMNS - 1 : c.col;
        row = (c.row > ROWS - 1) ? ROWS - 1 : c.row;
        case (c.mode)
            MODE_PUT: begin
                screen_put(c.code);
                r.wr = c.upd;
            end
            MODE_CLEAR: shadow_reset();
            MODE_MOVE: begin
                shadow_col = col;
                shadow_row = row;
                r.wr = c.upd;
            end
            MODE_SCROLL: begin
                screen_scroll(int'(c.count));
                r.wr = c.upd;
            end
            MODE_READ: begin
                entry  = shadow_screen[row * COLUMNS + col];
                r.ch   = entry[CHAR_W-1:0];
                r.attr = entry[CELL_W-1:CHAR_W];
            end
            default: ;
        endcase
        r.pos = POS_W'(shadow_row * COLUMNS + shadow_col);
        return r;
    endfunction

    function automatic t_cmd scrambled_cmd(logic [MODE_W-1:0] mode);
        t_cmd c;
        c.mode  = mode;
        c.code  = CHAR_W'($urandom());
        c.col   = COL_W'($urandom());
        c.row   = ROW_W'($urandom());
        c.count = CNT_W'($urandom());
        c.upd   = 1'($urandom());
        return c;
    endfunction

    // start stays high across back-to-back beats; lowered only for a gap or a drain
    task automatic send_cmd(t_cmd c);
        int gap;
        gap = 0;
        if (gaps_on)
            while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_mode          <= c.mode;
        i_char_code     <= c.code;
        i_column        <= c.col;
        i_row           <= c.row;
        i_scroll_count  <= c.count;
        i_update_cursor <= c.upd;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        awaited_status.push_back(console_step(c));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (awaited_status.size() != 0 || o_busy !== 1'b0);
    endtask

    task automatic write_colours(logic [NIB_W-1:0] fg, logic [NIB_W-1:0] bg);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FG;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        shadow_fg = fg;
        i_cfg_index <= CFG_BG;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        shadow_bg = bg;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_contents();
        t_cmd c;
        c = scrambled_cmd(MODE_READ);
        c.col = '0;
        c.row = '0;
        send_cmd(c);
        // beyond the last column and row: reads the bottom-right cell
        c = scrambled_cmd(MODE_READ);
        c.col = '1;
        c.row = '1;
        send_cmd(c);
    endtask

    task automatic test_control_codes();
        t_cmd c;
        logic [CHAR_W-1:0] seq [10];
        seq = '{8'h41, 8'hFF, CH_TAB, CH_BS, CH_CR, CH_BS, CH_FF, CH_LF, 8'h00, CH_LF};
        foreach (seq[i]) begin
            c = scrambled_cmd(MODE_PUT);
            c.code = seq[i];
            send_cmd(c);
        end
        c = scrambled_cmd(MODE_READ);
        c.col = '0;
        c.row = '0;
        send_cmd(c);
        c.col = COL_W'(1);
        send_cmd(c);
    endtask

    task automatic test_move_and_wrap();
        t_cmd c;
        c = scrambled_cmd(MODE_MOVE);
        c.col = '1;
        c.row = '1;
        c.upd = 1'b1;
        send_cmd(c);
        // last cell of the screen: wraps and pushes everything up a line
        c = scrambled_cmd(MODE_PUT);
        c.code = "Z";
        send_cmd(c);
        c = scrambled_cmd(MODE_READ);
        c.col = COL_W'(COLUMNS - 1);
        c.row = ROW_W'(ROWS - 2);
        send_cmd(c);
    endtask

    task automatic test_scroll_counts();
        t_cmd c;
        c = scrambled_cmd(MODE_SCROLL);
        c.count = '0;
        c.upd   = 1'b1;
        send_cmd(c);
        c.count = CNT_W'(2);
        send_cmd(c);
        c.count = '1;
        send_cmd(c);
    endtask

    task automatic test_unused_modes();
        send_cmd(scrambled_cmd(MODE_SPARE_FIRST));
        send_cmd(scrambled_cmd(MODE_SPARE_LAST));
    endtask

    task automatic test_colours();
        t_cmd put;
        t_cmd rd;
        put = scrambled_cmd(MODE_PUT);
        put.code = "Q";
        rd = scrambled_cmd(MODE_READ);
        rd.col = '0;
        rd.row = '0;
        write_colours(4'h0, 4'hF);
        send_cmd(put);
        send_cmd(rd);
        // clear also puts the colours back to their reset values
        send_cmd(scrambled_cmd(MODE_CLEAR));
        send_cmd(put);
        send_cmd(rd);
    endtask

    task automatic test_random_traffic(int n_items);
        t_cmd c;
        int   pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            c = scrambled_cmd(MODE_PUT);
            if (pick < 62) begin
                pick = $urandom_range(99);
                if (pick < 10)
                    c.code = control_codes[$urandom_range(4)];
                else if (pick < 60)
                    c.code = CHAR_W'($urandom_range(CH_TILDE, CH_SPACE));
            end else if (pick < 82) begin
                c.mode = MODE_READ;
                // mostly look back along the line being written
                if ($urandom_range(99) < 60) begin
                    c.row = ROW_W'(shadow_row);
                    c.col = COL_W'($urandom_range(COLUMNS - 1));
                end
            end else if (pick < 92) begin
                c.mode = MODE_MOVE;
            end else if (pick < 96) begin
                c.mode = MODE_SCROLL;
                pick = $urandom_range(9);
                if (pick == 0)
                    c.count = '0;
                else if (pick == 1)
                    c.count = CNT_W'($urandom_range(31, ROWS));
                else
                    c.count = CNT_W'($urandom_range(4, 1));
            end else if (pick < 98) begin
                c.mode = MODE_CLEAR;
            end else begin
                c.mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
            end
            send_cmd(c);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (awaited_status.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("result beat with nothing outstanding at cycle %0d", cycle_count);
            end else begin
                want = awaited_status.pop_front();
                if (o_cursor_pos !== want.pos || o_cursor_write !== want.wr ||
                    o_cell_char !== want.ch || o_cell_attr !== want.attr) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $write("mismatch at cycle %0d (expected/actual): pos %0d/%0d ",
                               cycle_count, want.pos, o_cursor_pos);
                        $display("wr %0b/%0b char %02h/%02h attr %02h/%02h",
                                 want.wr, o_cursor_write, want.ch, o_cell_char,
                                 want.attr, o_cell_attr);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL text_console_writer");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_mode          <= MODE_PUT;
        i_char_code     <= '0;
        i_column        <= '0;
        i_row           <= '0;
        i_scroll_count  <= '0;
        i_update_cursor <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_FG;
        i_cfg_data      <= '0;
        shadow_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_control_codes();
        test_move_and_wrap();
        test_scroll_counts();
        test_unused_modes();
        test_colours();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       write_colours(4'h0, 4'h0);
                1:       write_colours(4'hF, 4'hF);
                default: write_colours(NIB_W'($urandom()), NIB_W'($urandom()));
            endcase
            gaps_on = (p != 2);
            test_random_traffic(PHASE_ITEMS);
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        fail_count += awaited_status.size();
        if (fail_count == 0)
            $display("PASS text_console_writer");
        else
            $display("FAIL text_console_writer");
        $finish;
    end

endmodule
